@@ hdl/ppc_pkg.sv @@
package ppc_pkg;

    // Sizing of the vertex store and coordinate format
    localparam int MAX_VERTICES = 256;
    localparam int COORD_W      = 32;
    localparam int VA_W         = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int STV_W        = 9;

    // One store entry: {closes, y, x}
    localparam int VTX_W = 2 * COORD_W + 1;

    // Edge test arithmetic widths: difference, product, cross product
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((2 * COORD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 + STV_W + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_END_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAY_END_Y = 1'd1;

    // Commands
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef logic signed [COORD_W-1:0] t_coord;

    // Control that travels with one edge into the edge test unit
    typedef struct packed {
        logic valid;
        logic poly_end;
        logic last;
    } t_edge_ctl;

    // Query outcome from the edge test unit
    typedef struct packed {
        logic done;
        logic in_poly;
    } t_edge_res;

endpackage

@@ hdl/ppc_ram.sv @@
module ppc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ppc_edge_unit.sv @@
module ppc_edge_unit
    import ppc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_edge_ctl i_ctl,
    input  t_coord    i_ax,
    input  t_coord    i_ay,
    input  t_coord    i_bx,
    input  t_coord    i_by,
    input  t_coord    i_px,
    input  t_coord    i_py,
    input  t_coord    i_rx,
    input  t_coord    i_ry,
    output t_edge_res o_res
);

    // Stage 1: coordinate differences
    t_edge_ctl                  r_s1_ctl;
    logic                       r_s1_skip;
    logic signed [DIFF_W-1:0]   r_drx, r_dry, r_dax, r_day, r_dbx, r_dby;
    logic signed [DIFF_W-1:0]   r_ex, r_ey, r_fx, r_fy, r_gx, r_gy;

    // Stage 2: products
    t_edge_ctl                  r_s2_ctl;
    logic                       r_s2_skip;
    logic signed [PROD_W-1:0]   r_m1a, r_m1b, r_m2a, r_m2b;
    logic signed [PROD_W-1:0]   r_m3a, r_m3b, r_m4a, r_m4b;

    // Stage 3: cross product signs
    t_edge_ctl                  r_s3_ctl;
    logic                       r_s3_skip;
    logic [3:0]                 r_neg;
    logic [3:0]                 r_nz;
    logic signed [CROSS_W-1:0]  c1, c2, c3, c4;

    // Stage 4: parity per polygon and query result
    logic                       cross_hit;
    logic                       n_par;
    logic                       r_par;
    logic                       r_inside;
    logic                       r_done;

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
        end
    end

    // Stage 1 data: ray from P to R, edge from A to B
    always_ff @(posedge i_clk) begin
        r_s1_skip <= (i_ax == i_bx) && (i_ay == i_by);
        r_drx     <= DIFF_W'(i_rx) - DIFF_W'(i_px);
        r_dry     <= DIFF_W'(i_ry) - DIFF_W'(i_py);
        r_dax     <= DIFF_W'(i_ax) - DIFF_W'(i_px);
        r_day     <= DIFF_W'(i_ay) - DIFF_W'(i_py);
        r_dbx     <= DIFF_W'(i_bx) - DIFF_W'(i_px);
        r_dby     <= DIFF_W'(i_by) - DIFF_W'(i_py);
        r_ex      <= DIFF_W'(i_bx) - DIFF_W'(i_ax);
        r_ey      <= DIFF_W'(i_by) - DIFF_W'(i_ay);
        r_fx      <= DIFF_W'(i_px) - DIFF_W'(i_ax);
        r_fy      <= DIFF_W'(i_py) - DIFF_W'(i_ay);
        r_gx      <= DIFF_W'(i_rx) - DIFF_W'(i_ax);
        r_gy      <= DIFF_W'(i_ry) - DIFF_W'(i_ay);
    end

    // Stage 2 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    // Stage 2 data: eight exact products of two differences
    always_ff @(posedge i_clk) begin
        r_s2_skip <= r_s1_skip;
        r_m1a     <= PROD_W'(r_drx) * PROD_W'(r_day);
        r_m1b     <= PROD_W'(r_dry) * PROD_W'(r_dax);
        r_m2a     <= PROD_W'(r_drx) * PROD_W'(r_dby);
        r_m2b     <= PROD_W'(r_dry) * PROD_W'(r_dbx);
        r_m3a     <= PROD_W'(r_ex) * PROD_W'(r_fy);
        r_m3b     <= PROD_W'(r_ey) * PROD_W'(r_fx);
        r_m4a     <= PROD_W'(r_ex) * PROD_W'(r_gy);
        r_m4b     <= PROD_W'(r_ey) * PROD_W'(r_gx);
    end

    // Cross products in full width
    assign c1 = CROSS_W'(r_m1a) - CROSS_W'(r_m1b);
    assign c2 = CROSS_W'(r_m2a) - CROSS_W'(r_m2b);
    assign c3 = CROSS_W'(r_m3a) - CROSS_W'(r_m3b);
    assign c4 = CROSS_W'(r_m4a) - CROSS_W'(r_m4b);

    // Stage 3 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else begin
            r_s3_ctl <= r_s2_ctl;
        end
    end

    // Stage 3 data: keep only sign and nonzero flags
    always_ff @(posedge i_clk) begin
        r_s3_skip <= r_s2_skip;
        r_neg     <= {c4[CROSS_W-1], c3[CROSS_W-1], c2[CROSS_W-1], c1[CROSS_W-1]};
        r_nz      <= {(c4 != '0), (c3 != '0), (c2 != '0), (c1 != '0)};
    end

    // Strict crossing: both sign pairs nonzero and opposite
    assign cross_hit = !r_s3_skip && (&r_nz)
                     && (r_neg[0] != r_neg[1]) && (r_neg[2] != r_neg[3]);
    assign n_par     = r_par ^ cross_hit;

    // Accumulate parity, fold it into the result at each polygon end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par    <= 1'b0;
            r_inside <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_start) begin
            r_par    <= 1'b0;
            r_inside <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_s3_ctl.valid && r_s3_ctl.last;
            if (r_s3_ctl.valid) begin
                if (r_s3_ctl.poly_end) begin
                    r_inside <= r_inside | n_par;
                    r_par    <= 1'b0;
                end else begin
                    r_par <= n_par;
                end
            end
        end
    end

    assign o_res.done    = r_done;
    assign o_res.in_poly = r_inside;

endmodule

@@ hdl/polygon_point_containment_top.sv @@
// Append, clear, unused command: the result is staged in the done state and goes into the
// output register once the result side is free; the next transaction is taken after that.
// Query over N vertices of closed polygons: the store is scanned, each edge passes the edge
// unit, then the result is staged the same way (N = 0 as an append); one vertex read per cycle.
// Reset (i_rst_n low, synchronous) empties the store counts and zeroes the ray end point;
// vertex memory contents are not cleared and are only read below the closed count.
module polygon_point_containment_top
    import ppc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COORD_W-1:0]     i_cfg_wdata,
    // Input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]   i_s_axis_tdata,  // coord_x, coord_y
    input  logic [1:0]             i_s_axis_tuser,  // command
    input  logic                   i_s_axis_tlast,  // closes_polygon
    // Result stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata   // status, inside_res, stored_vertices
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         r_state;
    logic               in_fire;
    logic               out_free;
    t_coord             in_x, in_y;

    t_coord             r_ray_x, r_ray_y;
    t_coord             r_px, r_py;
    logic [CNT_W-1:0]   r_vtx_total;
    logic [CNT_W-1:0]   r_closed_total;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               rd_last;

    logic               ram_we;
    logic [VTX_W-1:0]   ram_rdata;
    t_coord             cur_x, cur_y;
    logic               cur_c;

    logic               r_dv;
    logic               r_dlast;
    logic               r_flush;
    logic               r_have_prev;
    t_coord             r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic               r_prev_c;

    t_edge_ctl          n_e_ctl, r_e_ctl;
    t_coord             n_e_bx, n_e_by;
    t_coord             r_e_ax, r_e_ay, r_e_bx, r_e_by;
    logic               q_start;
    t_edge_res          edge_res;

    logic               r_res_status, r_res_inside;
    logic               r_ov, r_out_status, r_out_inside;
    logic [CNT_W-1:0]   r_out_cnt;

    assign in_x     = i_s_axis_tdata[COORD_W-1:0];
    assign in_y     = i_s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_fire  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign rd_last  = (r_rd_idx == r_closed_total - CNT_W'(1));
    assign ram_we   = in_fire && (i_s_axis_tuser == CMD_APPEND)
                    && (r_vtx_total < CNT_W'(MAX_VERTICES));
    assign q_start  = in_fire && (i_s_axis_tuser == CMD_QUERY);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_x <= '0;
            r_ray_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RAY_END_X: r_ray_x <= i_cfg_wdata;
                REG_RAY_END_Y: r_ray_y <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Vertex store: appends and queries never overlap, so no forwarding is needed
    ppc_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_vtx_total[VA_W-1:0]),
        .i_wdata ({i_s_axis_tlast, in_y, in_x}),
        .i_raddr (r_rd_idx[VA_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign cur_x = ram_rdata[COORD_W-1:0];
    assign cur_y = ram_rdata[2*COORD_W-1:COORD_W];
    assign cur_c = ram_rdata[VTX_W-1];

    // Sequencer: take a command, scan the store for a query, stage the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_vtx_total    <= '0;
            r_closed_total <= '0;
            r_rd_idx       <= '0;
            r_dv           <= 1'b0;
            r_dlast        <= 1'b0;
            r_res_status   <= 1'b0;
            r_res_inside   <= 1'b0;
        end else begin
            r_dv    <= (r_state == ST_SCAN);
            r_dlast <= (r_state == ST_SCAN) && rd_last;
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_res_status <= 1'b0;
                        r_res_inside <= 1'b0;
                        r_rd_idx     <= '0;
                        r_state      <= ST_DONE;
                        case (i_s_axis_tuser)
                            CMD_APPEND: begin
                                if (ram_we) begin
                                    r_vtx_total <= r_vtx_total + CNT_W'(1);
                                    if (i_s_axis_tlast) begin
                                        r_closed_total <= r_vtx_total + CNT_W'(1);
                                    end
                                end else begin
                                    r_res_status <= 1'b1;
                                end
                            end
                            CMD_QUERY: begin
                                if (r_closed_total != '0) begin
                                    r_state <= ST_SCAN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_vtx_total    <= '0;
                                r_closed_total <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (rd_last) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                end
                ST_WAIT: begin
                    if (edge_res.done) begin
                        r_res_inside <= edge_res.in_poly;
                        r_state      <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the query point for the whole scan
    always_ff @(posedge i_clk) begin
        if (q_start) begin
            r_px <= in_x;
            r_py <= in_y;
        end
    end

    // Edge feeder control: each arriving vertex closes the edge of the one before it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_flush     <= 1'b0;
        end else begin
            r_flush <= r_dv && r_dlast;
            if (q_start) begin
                r_have_prev <= 1'b0;
            end else if (r_dv) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    // Edge feeder data: previous vertex and first vertex of the open polygon
    always_ff @(posedge i_clk) begin
        if (r_dv) begin
            r_prev_x <= cur_x;
            r_prev_y <= cur_y;
            r_prev_c <= cur_c;
            if (!r_have_prev || r_prev_c) begin
                r_first_x <= cur_x;
                r_first_y <= cur_y;
            end
        end
    end

    // Pick the edge end: next vertex, or the polygon's first after a closing vertex
    always_comb begin
        n_e_ctl = '0;
        n_e_bx  = cur_x;
        n_e_by  = cur_y;
        if (r_flush) begin
            n_e_ctl.valid    = 1'b1;
            n_e_ctl.poly_end = 1'b1;
            n_e_ctl.last     = 1'b1;
            n_e_bx           = r_first_x;
            n_e_by           = r_first_y;
        end else if (r_dv && r_have_prev) begin
            n_e_ctl.valid    = 1'b1;
            n_e_ctl.poly_end = r_prev_c;
            if (r_prev_c) begin
                n_e_bx = r_first_x;
                n_e_by = r_first_y;
            end
        end
    end

    // Register the edge into the test unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl <= '0;
        end else begin
            r_e_ctl <= n_e_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_ax <= r_prev_x;
        r_e_ay <= r_prev_y;
        r_e_bx <= n_e_bx;
        r_e_by <= n_e_by;
    end

    ppc_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (q_start),
        .i_ctl   (r_e_ctl),
        .i_ax    (r_e_ax),
        .i_ay    (r_e_ay),
        .i_bx    (r_e_bx),
        .i_by    (r_e_by),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_rx    (r_ray_x),
        .i_ry    (r_ray_y),
        .o_res   (edge_res)
    );

    // Output register: load when the result is staged, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_inside <= r_res_inside;
            r_out_cnt    <= r_vtx_total;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OUT_DATA_W'({STV_W'(r_out_cnt), r_out_inside, r_out_status});

`ifndef SYNTHESIS
    a_closed_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_closed_total <= r_vtx_total)
        else $error("closed vertex count exceeds stored count");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vtx_total <= CNT_W'(MAX_VERTICES))
        else $error("stored vertex count beyond store depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_idx < r_closed_total))
        else $error("scan reads beyond closed vertices");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_res.done |-> (r_state == ST_WAIT))
        else $error("edge unit finished outside a query");

    a_flush_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> ($past(r_dv) && $past(r_dlast)))
        else $error("closing edge without last vertex");
`endif

endmodule

@@ test/containment_checker.sv @@
module containment_checker
    import ppc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port, observed
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [COORD_W-1:0]    i_cfg_wdata,
    // Input stream, observed
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // coord_x, coord_y
    input  logic [1:0]            i_s_tuser,   // command
    input  logic                  i_s_tlast,   // closes_polygon
    // Result stream, observed
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,   // status, inside_res, stored_vertices
    output int                    o_mismatches,
    output int                    o_answers_due
);

    // Result layout, lowest bit last in the list
    typedef struct packed {
        logic [STV_W-1:0] stored;
        logic             in_res;
        logic             status;
    } t_answer;

    localparam int PRINT_CAP = 200;
    localparam int DUE_DEPTH = 16;

    // Private copy of the block state
    t_coord      far_x, far_y;
    t_coord      vert_x [MAX_VERTICES];
    t_coord      vert_y [MAX_VERTICES];
    logic        vert_closes [MAX_VERTICES];
    int unsigned held_total, closed_total;

    // Expected answers in arrival order, kept in a ring
    t_answer     due_buf [DUE_DEPTH];
    int          due_head  = 0;
    int          due_count = 0;
    int          fail_count = 0;

    task automatic report(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    endtask

    // Exact coordinate difference, one bit wider than a coordinate
    function automatic logic signed [DIFF_W-1:0] coord_diff(input t_coord a, input t_coord b);
        logic signed [DIFF_W-1:0] wa, wb;
        wa = DIFF_W'(a);
        wb = DIFF_W'(b);
        return wa - wb;
    endfunction

    // Sign of ax*by - ay*bx, computed without any loss
    function automatic int cross_sign(input logic signed [DIFF_W-1:0] ax, ay, bx, by);
        logic signed [CROSS_W-1:0] wax, way, wbx, wby, c;
        wax = CROSS_W'(ax);
        way = CROSS_W'(ay);
        wbx = CROSS_W'(bx);
        wby = CROSS_W'(by);
        c   = wax * wby - way * wbx;
        if (c == 0)
            return 0;
        return (c < 0) ? -1 : 1;
    endfunction

    // Proper crossing of segment p1-p2 with segment q1-q2; touching counts as none
    function automatic bit strict_cross(input t_coord p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y);
        int s1, s2, s3, s4;
        s1 = cross_sign(coord_diff(p2x, p1x), coord_diff(p2y, p1y),
                        coord_diff(q1x, p1x), coord_diff(q1y, p1y));
        s2 = cross_sign(coord_diff(p2x, p1x), coord_diff(p2y, p1y),
                        coord_diff(q2x, p1x), coord_diff(q2y, p1y));
        if (s1 == 0 || s2 == 0 || s1 == s2)
            return 1'b0;
        s3 = cross_sign(coord_diff(q2x, q1x), coord_diff(q2y, q1y),
                        coord_diff(p1x, q1x), coord_diff(p1y, q1y));
        s4 = cross_sign(coord_diff(q2x, q1x), coord_diff(q2y, q1y),
                        coord_diff(p2x, q1x), coord_diff(p2y, q1y));
        return (s3 != 0 && s4 != 0 && s3 != s4);
    endfunction

    // Odd crossing count against any closed polygon means inside
    function automatic logic point_inside(input t_coord px, input t_coord py);
        int unsigned i, start, nxt;
        int          crossings;
        logic        hit_any;
        start     = 0;
        crossings = 0;
        hit_any   = 1'b0;
        for (i = 0; i < closed_total && i < MAX_VERTICES; i++) begin
            nxt = vert_closes[i] ? start : i + 1;
            if (nxt >= MAX_VERTICES)
                nxt = start;
            // skip edges of zero length
            if (vert_x[i] != vert_x[nxt] || vert_y[i] != vert_y[nxt]) begin
                if (strict_cross(px, py, far_x, far_y,
                                 vert_x[i], vert_y[i], vert_x[nxt], vert_y[nxt]))
                    crossings++;
            end
            if (vert_closes[i]) begin
                if (crossings[0])
                    hit_any = 1'b1;
                crossings = 0;
                start     = i + 1;
            end
        end
        return hit_any;
    endfunction

    // Watch both streams: compare results first, then predict for the new item
    always @(posedge i_clk) begin : watch
        t_answer got, want;
        t_coord  x, y;
        if (!i_rst_n) begin
            far_x        = '0;
            far_y        = '0;
            held_total   = 0;
            closed_total = 0;
            due_head     = 0;
            due_count    = 0;
        end else begin
            // Check one result transaction
            if (i_m_tvalid && i_m_tready) begin
                got = t_answer'(i_m_tdata[STV_W+1:0]);
                if (due_count == 0) begin
                    report("result with nothing expected", int'(i_m_tdata), -1);
                end else begin
                    want      = due_buf[due_head];
                    due_head  = (due_head + 1) % DUE_DEPTH;
                    due_count = due_count - 1;
                    if (got.status != want.status)
                        report("status", int'(got.status), int'(want.status));
                    if (got.in_res != want.in_res)
                        report("inside_res", int'(got.in_res), int'(want.in_res));
                    if (got.stored != want.stored)
                        report("stored_vertices", int'(got.stored), int'(want.stored));
                end
            end

            // Track the far point registers
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RAY_END_X: far_x = t_coord'(i_cfg_wdata);
                    REG_RAY_END_Y: far_y = t_coord'(i_cfg_wdata);
                    default: ;
                endcase
            end

            // Predict the answer to one input transaction
            if (i_s_tvalid && i_s_tready) begin
                x    = t_coord'(i_s_tdata[COORD_W-1:0]);
                y    = t_coord'(i_s_tdata[2*COORD_W-1:COORD_W]);
                want = '0;
                case (i_s_tuser)
                    CMD_APPEND: begin
                        if (held_total >= MAX_VERTICES) begin
                            want.status = 1'b1;
                        end else begin
                            vert_x[held_total]      = x;
                            vert_y[held_total]      = y;
                            vert_closes[held_total] = i_s_tlast;
                            held_total++;
                            if (i_s_tlast)
                                closed_total = held_total;
                        end
                    end
                    CMD_QUERY: want.in_res = point_inside(x, y);
                    CMD_CLEAR: begin
                        held_total   = 0;
                        closed_total = 0;
                    end
                    default: ;
                endcase
                want.stored = STV_W'(held_total);
                if (due_count >= DUE_DEPTH) begin
                    report("expected answers beyond buffer", due_count, DUE_DEPTH - 1);
                end else begin
                    due_buf[(due_head + due_count) % DUE_DEPTH] = want;
                    due_count = due_count + 1;
                end
            end
        end
        o_mismatches  <= fail_count;
        o_answers_due <= due_count;
    end

endmodule

@@ test/tb_top.sv @@
module tb_top;
    import ppc_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 24;
    localparam int         CLEAR_ABOVE = 48;
    localparam int         LONG_HOLD   = 300;
    localparam int         END_WAIT    = 300;
    localparam int         STALL_LIMIT = 3000;
    localparam t_coord     C_MAX       = 32'sh7FFF_FFFF;
    localparam t_coord     C_MIN       = 32'sh8000_0000;

    logic                  i_clk;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = REG_RAY_END_X;
    logic [COORD_W-1:0]    i_cfg_wdata     = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;   // coord_x, coord_y
    logic [1:0]            i_s_axis_tuser  = CMD_APPEND;   // command
    logic                  i_s_axis_tlast  = 1'b0;   // closes_polygon
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;   // status, inside_res, stored_vertices

    int mismatch_count;
    int answers_due;
    int idle_cycles = 0;

    // Sender bookkeeping
    bit offering   = 1'b0;
    int burst_left = 1;
    int sent       = 0;
    int held       = 0;

    // Far point per random phase, extremes first
    t_coord far_xs [PHASES] = '{C_MAX, C_MIN, 32'sd0, C_MAX, C_MIN, 32'sd0};
    t_coord far_ys [PHASES] = '{32'sd7, C_MIN, 32'sd0, C_MAX, C_MAX, 32'sd0};

    polygon_point_containment_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    containment_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_s_tvalid    (i_s_axis_tvalid),
        .i_s_tready    (o_s_axis_tready),
        .i_s_tdata     (i_s_axis_tdata),
        .i_s_tuser     (i_s_axis_tuser),
        .i_s_tlast     (i_s_axis_tlast),
        .i_m_tvalid    (o_m_axis_tvalid),
        .i_m_tready    (i_m_axis_tready),
        .i_m_tdata     (o_m_axis_tdata),
        .o_mismatches  (mismatch_count),
        .o_answers_due (answers_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drop valid if it is up
    task automatic stop_offer();
        if (offering) begin
            i_s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Offer one item, hold until the transaction, then pace the burst
    task automatic send_item(input logic [1:0] cmd, input t_coord x, input t_coord y,
                             input logic closes);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {y, x};
        i_s_axis_tuser  <= cmd;
        i_s_axis_tlast  <= closes;
        offering = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent++;
        if (cmd == CMD_APPEND && held < MAX_VERTICES)
            held++;
        else if (cmd == CMD_CLEAR)
            held = 0;
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                stop_offer();
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Pause the sender until every answer is back
    task automatic wait_idle();
        stop_offer();
        @(posedge i_clk);
        while (answers_due != 0) @(posedge i_clk);
    endtask

    task automatic write_ray_end(input t_coord x, input t_coord y);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_RAY_END_X;
        i_cfg_wdata <= x;
        @(posedge i_clk);
        i_cfg_idx   <= REG_RAY_END_Y;
        i_cfg_wdata <= y;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_coord near(input t_coord c, input int unsigned r);
        return c + t_coord'($urandom_range(0, 2 * r)) - t_coord'(r);
    endfunction

    // Tiny grids give many collinear and repeated points
    function automatic int unsigned pick_radius();
        case ($urandom_range(0, 3))
            0:       return 4;
            1:       return $urandom_range(16, 4096);
            2:       return 1 << $urandom_range(12, 24);
            default: return 1 << 30;
        endcase
    endfunction

    function automatic t_coord pick_center();
        if ($urandom_range(0, 3) == 0)
            return t_coord'($urandom);
        return t_coord'($urandom_range(0, 32'h2000_0000)) - t_coord'(32'h1000_0000);
    endfunction

    function automatic t_coord any_coord();
        return t_coord'($urandom);
    endfunction

    // One polygon, closed or left open, followed by queries around it
    task automatic polygon_and_queries(input bit closed);
        t_coord      cx, cy;
        int unsigned r;
        int          n, k, j;
        cx = pick_center();
        cy = pick_center();
        r  = pick_radius();
        n  = $urandom_range(3, 8);
        for (j = 0; j < n; j++)
            send_item(CMD_APPEND, near(cx, r), near(cy, r), closed && j == n - 1);
        k = $urandom_range(1, 5);
        for (j = 0; j < k; j++)
            send_item(CMD_QUERY, near(cx, r + r / 2), near(cy, r + r / 2),
                      1'($urandom_range(0, 1)));
    endtask

    // Fill the store to the brim, then push past it and query the full store
    task automatic fill_store();
        t_coord      cx, cy;
        int unsigned r;
        int          n, j;
        send_item(CMD_CLEAR, any_coord(), any_coord(), 1'($urandom_range(0, 1)));
        cx = 0;
        cy = 0;
        r  = 4;
        while (held < MAX_VERTICES) begin
            cx = pick_center();
            cy = pick_center();
            r  = pick_radius();
            n  = $urandom_range(3, 6);
            for (j = 0; j < n && held < MAX_VERTICES; j++)
                send_item(CMD_APPEND, near(cx, r), near(cy, r),
                          j == n - 1 || held == MAX_VERTICES - 1);
        end
        for (j = 0; j < 4; j++)
            send_item(CMD_APPEND, any_coord(), any_coord(), j[0]);
        send_item(CMD_QUERY, near(cx, r), near(cy, r), 1'b0);
        send_item(CMD_QUERY, near(cx, r), near(cy, r), 1'b1);
        send_item(CMD_QUERY, any_coord(), any_coord(), 1'b0);
    endtask

    // Result side: a long hold-off early on, then a changing stall pattern
    initial begin : result_sink
        int seg, mode, hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        i_m_axis_tready <= 1'b1;
        repeat (20) @(posedge i_clk);
        i_m_axis_tready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge i_clk);
        forever begin
            seg  = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (seg) begin
                case (mode)
                    1:       i_m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: i_m_axis_tready <= 1'b1;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int ph, phase_start, pick, j;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_ray_end(C_MAX, 32'sd7);

        // Directed: unused command, empty store, square, open tail, zero-length edge
        send_item(CMD_UNUSED, C_MAX, C_MIN, 1'b1);
        send_item(CMD_QUERY, 32'sd50, 32'sd50, 1'b0);
        send_item(CMD_CLEAR, C_MIN, C_MAX, 1'b1);
        send_item(CMD_APPEND, 32'sd0, 32'sd0, 1'b0);
        send_item(CMD_APPEND, 32'sd100, 32'sd0, 1'b0);
        send_item(CMD_APPEND, 32'sd100, 32'sd100, 1'b0);
        send_item(CMD_APPEND, 32'sd0, 32'sd100, 1'b1);
        send_item(CMD_QUERY, 32'sd50, 32'sd50, 1'b0);
        send_item(CMD_QUERY, 32'sd150, 32'sd50, 1'b0);
        send_item(CMD_QUERY, 32'sd100, 32'sd50, 1'b0);
        send_item(CMD_QUERY, 32'sd0, 32'sd0, 1'b1);
        send_item(CMD_APPEND, 32'sd200, 32'sd200, 1'b0);
        send_item(CMD_APPEND, 32'sd200, 32'sd200, 1'b0);
        send_item(CMD_APPEND, 32'sd300, 32'sd200, 1'b0);
        send_item(CMD_APPEND, 32'sd300, 32'sd300, 1'b1);
        send_item(CMD_QUERY, 32'sd280, 32'sd240, 1'b0);
        // extreme coordinates in one large triangle
        send_item(CMD_APPEND, C_MAX, C_MIN, 1'b0);
        send_item(CMD_APPEND, C_MIN, C_MAX, 1'b0);
        send_item(CMD_APPEND, 32'sd0, 32'sd0, 1'b1);
        send_item(CMD_QUERY, C_MIN, C_MIN, 1'b0);
        send_item(CMD_QUERY, 32'sd0, 32'sd1, 1'b0);
        send_item(CMD_APPEND, 32'sd5, 32'sd5, 1'b0);
        send_item(CMD_QUERY, 32'sd50, 32'sd50, 1'b0);
        send_item(CMD_CLEAR, 32'sd0, 32'sd0, 1'b0);
        send_item(CMD_QUERY, 32'sd50, 32'sd50, 1'b0);

        // Random phases, each under its own far point
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph == PHASES - 1)
                write_ray_end(any_coord(), any_coord());
            else
                write_ray_end(far_xs[ph], far_ys[ph]);
            if (ph == 3)
                fill_store();
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (held > CLEAR_ABOVE) begin
                    send_item(CMD_CLEAR, any_coord(), any_coord(), 1'($urandom_range(0, 1)));
                end else if (pick < 65) begin
                    polygon_and_queries(1'b1);
                end else if (pick < 80) begin
                    for (j = $urandom_range(1, 4); j > 0; j--)
                        send_item(2'($urandom_range(0, 3)), any_coord(), any_coord(),
                                  1'($urandom_range(0, 1)));
                end else if (pick < 90) begin
                    polygon_and_queries(1'b0);
                end else if (pick < 96) begin
                    send_item(CMD_CLEAR, any_coord(), any_coord(), 1'($urandom_range(0, 1)));
                end else begin
                    wait_idle();
                end
            end
        end

        // Drain, then allow for any stray result
        wait_idle();
        repeat (END_WAIT) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
